// ----- rtl/ssf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types, codes and fixed-point helpers of the state-space filter.
// ----------------------------------------------------------------------------
package ssf_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;

    localparam int MAX_STATES_DEF  = 4;
    localparam int MAX_INPUTS_DEF  = 2;
    localparam int MAX_OUTPUTS_DEF = 2;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 192;
    localparam int OUT_TUSER_W = 2;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef enum logic [1:0] {
        MODE_COEF  = 2'd0,
        MODE_STATE = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_C = 2'd2,
        SEL_D = 2'd3
    } msel_t;

    typedef enum logic [2:0] {
        REG_STATES_USED  = 3'd0,
        REG_INPUTS_USED  = 3'd1,
        REG_OUTPUTS_USED = 3'd2,
        REG_USE_B        = 3'd3,
        REG_USE_C        = 3'd4,
        REG_USE_D        = 3'd5
    } reg_idx_t;

    // exact product rounded half up to frac fraction bits
    function automatic prod_t fx_mul(data_t a, data_t b, int frac);
        prod_t p;
        p = PROD_W'(a) * PROD_W'(b);
        p = p + (prod_t'(1) <<< (frac - 1));
        return p >>> frac;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ssf_dot_row.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssf_dot_row
// One row of the filter: rounded products summed exactly, then saturated.
// ----------------------------------------------------------------------------
module ssf_dot_row #(
    parameter int TERMS     = ssf_pkg::MAX_STATES_DEF + ssf_pkg::MAX_INPUTS_DEF,
    parameter int FRAC_BITS = ssf_pkg::FRAC_BITS_DEF
) (
    input  ssf_pkg::data_t   coef [TERMS],
    input  ssf_pkg::data_t   opnd [TERMS],
    input  logic [TERMS-1:0] term_en,
    output ssf_pkg::data_t   result,
    output logic             ovf
);
    import ssf_pkg::*;

    localparam int SUM_W = PROD_W + $clog2(TERMS + 1);

    logic signed [SUM_W-1:0] sum;
    logic                    all_ones;
    logic                    all_zeros;

    always_comb
    begin
        sum = '0;
        for (int t = 0; t < TERMS; t++)
        begin
            if (term_en[t])
            begin
                sum = sum + SUM_W'(fx_mul(coef[t], opnd[t], FRAC_BITS));
            end
        end
    end

    // the sum fits when every bit above the result's sign bit matches it
    assign all_ones  = &sum[SUM_W-1:DATA_W-1];
    assign all_zeros = ~|sum[SUM_W-1:DATA_W-1];
    assign ovf       = !(all_ones || all_zeros);

    always_comb
    begin
        if (!ovf)
        begin
            result = sum[DATA_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            result = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/state_space_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// state_space_filter
// Discrete state-space filter y = C x + D u, x' = A x + B u in signed fixed
// point, with coefficient and initial-state loading over the input stream.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  s_axis   | in        | tvalid / tready         | tuser: mode, matrix_sel
//           |           |                         | tdata: row, col, value, u
//  m_axis   | out       | tvalid / tready         | tuser: kind, overflow
//           |           |                         | tdata: y_first..next_x3
//  apb      | in/out    | psel, penable, pready   | six config registers at 4*i
//
//  one transaction per clock sustained while m_axis_tready stays high; an accepted
//  transaction waits in the input register, passes the row multipliers and adder
//  trees combinationally and then sits in the result register with m_axis_tvalid high
//  each transaction takes effect as it enters the result register, in order
//  reset clears the coefficient store and state and sets all counts and flags to one
//  an m_axis stall holds the result register; s_axis takes at most one more, then stalls
//
module state_space_filter #(
    parameter int MAX_STATES  = ssf_pkg::MAX_STATES_DEF,
    parameter int MAX_INPUTS  = ssf_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = ssf_pkg::MAX_OUTPUTS_DEF,
    parameter int FRAC_BITS   = ssf_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // row[1:0], col[3:2], value[35:4], u_first[67:36], u_second[99:68], zero
    input  logic [ssf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode[1:0], matrix_sel[3:2]
    input  logic [ssf_pkg::IN_TUSER_W-1:0]     s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // y_first[31:0], y_second[63:32], next_x0[95:64], next_x1[127:96],
    // next_x2[159:128], next_x3[191:160]
    output logic [ssf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind[0], overflow[1]
    output logic [ssf_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ssf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ssf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ssf_pkg::*;

    localparam int N_W   = $clog2(MAX_STATES + 1);
    localparam int M_W   = $clog2(MAX_INPUTS + 1);
    localparam int P_W   = $clog2(MAX_OUTPUTS + 1);
    localparam int TERMS = MAX_STATES + MAX_INPUTS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0] states_used_reg;
    logic [1:0] inputs_used_reg;
    logic [1:0] outputs_used_reg;
    logic       use_b_reg;
    logic       use_c_reg;
    logic       use_d_reg;
    logic       cfg_write;
    reg_idx_t   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_used_reg  <= 3'd1;
            inputs_used_reg  <= 2'd1;
            outputs_used_reg <= 2'd1;
            use_b_reg        <= 1'b1;
            use_c_reg        <= 1'b1;
            use_d_reg        <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_STATES_USED:  states_used_reg  <= pwdata[2:0];
                REG_INPUTS_USED:  inputs_used_reg  <= pwdata[1:0];
                REG_OUTPUTS_USED: outputs_used_reg <= pwdata[1:0];
                REG_USE_B:        use_b_reg        <= pwdata[0];
                REG_USE_C:        use_c_reg        <= pwdata[0];
                REG_USE_D:        use_d_reg        <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_STATES_USED:  prdata = APB_DATA_W'(states_used_reg);
            REG_INPUTS_USED:  prdata = APB_DATA_W'(inputs_used_reg);
            REG_OUTPUTS_USED: prdata = APB_DATA_W'(outputs_used_reg);
            REG_USE_B:        prdata = APB_DATA_W'(use_b_reg);
            REG_USE_C:        prdata = APB_DATA_W'(use_c_reg);
            REG_USE_D:        prdata = APB_DATA_W'(use_d_reg);
            default:          prdata = '0;
        endcase
    end

    // effective counts: zero reads as one, too large reads as the maximum
    logic [N_W-1:0] n_eff;
    logic [M_W-1:0] m_eff;
    logic [P_W-1:0] p_eff;

    always_comb
    begin
        if (states_used_reg == 3'd0)
            n_eff = N_W'(1);
        else if (int'(states_used_reg) > MAX_STATES)
            n_eff = N_W'(MAX_STATES);
        else
            n_eff = N_W'(states_used_reg);

        if (inputs_used_reg == 2'd0)
            m_eff = M_W'(1);
        else if (int'(inputs_used_reg) > MAX_INPUTS)
            m_eff = M_W'(MAX_INPUTS);
        else
            m_eff = M_W'(inputs_used_reg);

        if (outputs_used_reg == 2'd0)
            p_eff = P_W'(1);
        else if (int'(outputs_used_reg) > MAX_OUTPUTS)
            p_eff = P_W'(MAX_OUTPUTS);
        else
            p_eff = P_W'(outputs_used_reg);
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    mode_t       in_mode_reg;
    msel_t       in_sel_reg;
    logic [1:0]  in_row_reg;
    logic [1:0]  in_col_reg;
    data_t       in_value_reg;
    data_t       in_u_first_reg;
    data_t       in_u_second_reg;

    logic        out_valid_reg;
    logic        advance;
    logic        commit;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign commit        = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg     <= mode_t'(s_axis_tuser[1:0]);
            in_sel_reg      <= msel_t'(s_axis_tuser[3:2]);
            in_row_reg      <= s_axis_tdata[1:0];
            in_col_reg      <= s_axis_tdata[3:2];
            in_value_reg    <= s_axis_tdata[35:4];
            in_u_first_reg  <= s_axis_tdata[67:36];
            in_u_second_reg <= s_axis_tdata[99:68];
        end
    end

    // ------------------------------------------------------------------
    // coefficient store and state vector, one register per entry
    // ------------------------------------------------------------------
    data_t coef_a_reg [MAX_STATES][MAX_STATES];
    data_t coef_b_reg [MAX_STATES][MAX_INPUTS];
    data_t coef_c_reg [MAX_OUTPUTS][MAX_STATES];
    data_t coef_d_reg [MAX_OUTPUTS][MAX_INPUTS];
    data_t x_reg      [MAX_STATES];
    data_t x_next     [MAX_STATES];
    data_t y_res      [MAX_OUTPUTS];
    logic  [MAX_STATES-1:0]  x_ovf;
    logic  [MAX_OUTPUTS-1:0] y_ovf;

    logic  is_coef;

    assign is_coef = (in_mode_reg == MODE_COEF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                for (int j = 0; j < MAX_STATES; j++)
                    coef_a_reg[i][j] <= '0;
                for (int j = 0; j < MAX_INPUTS; j++)
                    coef_b_reg[i][j] <= '0;
                x_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_OUTPUTS; i++)
            begin
                for (int j = 0; j < MAX_STATES; j++)
                    coef_c_reg[i][j] <= '0;
                for (int j = 0; j < MAX_INPUTS; j++)
                    coef_d_reg[i][j] <= '0;
            end
        end
        else if (commit)
        begin
            // out of range rows and columns match no entry and are dropped
            for (int i = 0; i < MAX_STATES; i++)
            begin
                for (int j = 0; j < MAX_STATES; j++)
                    if (is_coef && in_sel_reg == SEL_A && int'(in_row_reg) == i
                        && int'(in_col_reg) == j)
                        coef_a_reg[i][j] <= in_value_reg;
                for (int j = 0; j < MAX_INPUTS; j++)
                    if (is_coef && in_sel_reg == SEL_B && int'(in_row_reg) == i
                        && int'(in_col_reg) == j)
                        coef_b_reg[i][j] <= in_value_reg;

                if (in_mode_reg == MODE_STATE && int'(in_row_reg) == i)
                    x_reg[i] <= in_value_reg;
                else if (in_mode_reg == MODE_STEP && i < int'(n_eff))
                    x_reg[i] <= x_next[i];
            end
            for (int i = 0; i < MAX_OUTPUTS; i++)
            begin
                for (int j = 0; j < MAX_STATES; j++)
                    if (is_coef && in_sel_reg == SEL_C && int'(in_row_reg) == i
                        && int'(in_col_reg) == j)
                        coef_c_reg[i][j] <= in_value_reg;
                for (int j = 0; j < MAX_INPUTS; j++)
                    if (is_coef && in_sel_reg == SEL_D && int'(in_row_reg) == i
                        && int'(in_col_reg) == j)
                        coef_d_reg[i][j] <= in_value_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // operand vector and term enables shared by all rows
    // ------------------------------------------------------------------
    data_t u_vec [MAX_INPUTS];
    logic [MAX_STATES-1:0] state_en;
    logic [MAX_INPUTS-1:0] input_en;

    genvar gi, gj;

    // input elements beyond the two carried in the stream read as zero
    for (gj = 0; gj < MAX_INPUTS; gj++)
    begin : g_u
        if (gj == 0)
        begin : g_first
            assign u_vec[gj] = in_u_first_reg;
        end
        else if (gj == 1)
        begin : g_second
            assign u_vec[gj] = in_u_second_reg;
        end
        else
        begin : g_zero
            assign u_vec[gj] = '0;
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_STATES; j++)
            state_en[j] = (j < int'(n_eff));
        for (int j = 0; j < MAX_INPUTS; j++)
            input_en[j] = (j < int'(m_eff));
    end

    // ------------------------------------------------------------------
    // state update rows: x' = A x + B u
    // ------------------------------------------------------------------
    for (gi = 0; gi < MAX_STATES; gi++)
    begin : g_xrow
        data_t            row_coef [TERMS];
        data_t            row_opnd [TERMS];
        logic [TERMS-1:0] row_en;

        always_comb
        begin
            for (int j = 0; j < MAX_STATES; j++)
            begin
                row_coef[j] = coef_a_reg[gi][j];
                row_opnd[j] = x_reg[j];
            end
            for (int j = 0; j < MAX_INPUTS; j++)
            begin
                row_coef[MAX_STATES + j] = coef_b_reg[gi][j];
                row_opnd[MAX_STATES + j] = u_vec[j];
            end
            row_en = {input_en & {MAX_INPUTS{use_b_reg}}, state_en};
        end

        ssf_dot_row #(
            .TERMS     (TERMS),
            .FRAC_BITS (FRAC_BITS)
        ) u_row (
            .coef    (row_coef),
            .opnd    (row_opnd),
            .term_en (row_en),
            .result  (x_next[gi]),
            .ovf     (x_ovf[gi])
        );
    end

    // ------------------------------------------------------------------
    // output rows: y = C x + D u from the current state
    // ------------------------------------------------------------------
    for (gi = 0; gi < MAX_OUTPUTS; gi++)
    begin : g_yrow
        data_t            row_coef [TERMS];
        data_t            row_opnd [TERMS];
        logic [TERMS-1:0] row_en;

        always_comb
        begin
            for (int j = 0; j < MAX_STATES; j++)
            begin
                row_coef[j] = coef_c_reg[gi][j];
                row_opnd[j] = x_reg[j];
            end
            for (int j = 0; j < MAX_INPUTS; j++)
            begin
                row_coef[MAX_STATES + j] = coef_d_reg[gi][j];
                row_opnd[MAX_STATES + j] = u_vec[j];
            end
            row_en = {input_en & {MAX_INPUTS{use_d_reg}}, state_en};
        end

        ssf_dot_row #(
            .TERMS     (TERMS),
            .FRAC_BITS (FRAC_BITS)
        ) u_row (
            .coef    (row_coef),
            .opnd    (row_opnd),
            .term_en (row_en),
            .result  (y_res[gi]),
            .ovf     (y_ovf[gi])
        );
    end

    // ------------------------------------------------------------------
    // result assembly
    // ------------------------------------------------------------------
    logic [MAX_OUTPUTS-1:0] y_active;
    logic                   is_step;
    logic                   ovf_any;
    data_t                  res_y [2];
    data_t                  res_x [4];

    assign is_step = (in_mode_reg == MODE_STEP);

    always_comb
    begin
        for (int i = 0; i < MAX_OUTPUTS; i++)
            y_active[i] = use_c_reg && (i < int'(p_eff));
    end

    // inactive outputs and rows never raise the flag
    assign ovf_any = |(y_ovf & y_active) || |(x_ovf & state_en);

    for (gi = 0; gi < 2; gi++)
    begin : g_resy
        if (gi < MAX_OUTPUTS)
        begin : g_on
            assign res_y[gi] = (is_step && y_active[gi]) ? y_res[gi] : '0;
        end
        else
        begin : g_off
            assign res_y[gi] = '0;
        end
    end

    for (gi = 0; gi < 4; gi++)
    begin : g_resx
        if (gi < MAX_STATES)
        begin : g_on
            assign res_x[gi] = (is_step && state_en[gi]) ? x_next[gi] : '0;
        end
        else
        begin : g_off
            assign res_x[gi] = '0;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TUSER_W-1:0] out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= {res_x[3], res_x[2], res_x[1], res_x[0], res_y[1], res_y[0]};
            out_user_reg <= {is_step && ovf_any, is_step};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
`default_nettype wire

// ----- bench/state_space_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// state_space_checker
// Watches the register port and both streams of the state-space filter, keeps
// its own copy of coefficients, state and settings, predicts every result and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module state_space_checker
    import ssf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic [OUT_TUSER_W-1:0]   m_axis_tuser,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output int                       fail_count,
    output int                       pending,
    output int                       step_results,
    output int                       saturated_results
);

    localparam int NS = MAX_STATES_DEF;
    localparam int NI = MAX_INPUTS_DEF;
    localparam int NO = MAX_OUTPUTS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;

    localparam int OFS_B = NS * NS;
    localparam int OFS_C = OFS_B + NS * NI;
    localparam int OFS_D = OFS_C + NO * NS;
    localparam int COEF_DEPTH = OFS_D + NO * NI;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic  kind;
        logic  overflow;
        data_t y_first;
        data_t y_second;
        data_t next_x0;
        data_t next_x1;
        data_t next_x2;
        data_t next_x3;
    } filter_result_t;

    data_t coef_mem [COEF_DEPTH];
    data_t state_mem [NS];
    logic [2:0] n_cfg;
    logic [1:0] m_cfg;
    logic [1:0] p_cfg;
    logic b_en;
    logic c_en;
    logic d_en;

    filter_result_t expected_outputs [$];
    int mismatches;
    int steps_seen;
    int saturated_seen;

    function automatic int clamp_count(int v, int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // exact product, rounded half up to the fraction width
    function automatic longint round_product(data_t a, data_t b);
        longint p;
        p = longint'(a) * longint'(b);
        p = p + (longint'(1) <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic data_t clip_to_word(longint v);
        if (v > WORD_MAX)
            return data_t'(WORD_MAX);
        if (v < WORD_MIN)
            return data_t'(WORD_MIN);
        return data_t'(v);
    endfunction

    // applies one input transaction to the local filter copy, returns its result
    function automatic filter_result_t advance_filter(mode_t mode, msel_t sel,
            logic [1:0] row, logic [1:0] col, data_t value, data_t u_first,
            data_t u_second);
        filter_result_t r;
        data_t u [NI];
        data_t y [NO];
        data_t nx [NS];
        longint acc;
        bit ovf;
        int n;
        int m;
        int p;
        int rows;
        int cols;
        int base;
        r = '0;
        ovf = 1'b0;
        case (mode)
            MODE_COEF: begin
                rows = (sel == SEL_A || sel == SEL_B) ? NS : NO;
                cols = (sel == SEL_A || sel == SEL_C) ? NS : NI;
                case (sel)
                    SEL_A:   base = 0;
                    SEL_B:   base = OFS_B;
                    SEL_C:   base = OFS_C;
                    default: base = OFS_D;
                endcase
                if (int'(row) < rows && int'(col) < cols)
                    coef_mem[base + int'(row) * cols + int'(col)] = value;
            end
            MODE_STATE: begin
                if (int'(row) < NS)
                    state_mem[row] = value;
            end
            MODE_STEP: begin
                n = clamp_count(int'(n_cfg), NS);
                m = clamp_count(int'(m_cfg), NI);
                p = clamp_count(int'(p_cfg), NO);
                u[0] = u_first;
                u[1] = u_second;
                for (int i = 0; i < NO; i++)
                    y[i] = '0;
                for (int i = 0; i < NS; i++)
                    nx[i] = '0;
                // outputs come from the state before the update
                if (c_en) begin
                    for (int i = 0; i < p; i++) begin
                        acc = 0;
                        for (int j = 0; j < n; j++)
                            acc += round_product(coef_mem[OFS_C + i * NS + j], state_mem[j]);
                        if (d_en)
                            for (int j = 0; j < m; j++)
                                acc += round_product(coef_mem[OFS_D + i * NI + j], u[j]);
                        ovf |= (acc > WORD_MAX) || (acc < WORD_MIN);
                        y[i] = clip_to_word(acc);
                    end
                end
                for (int i = 0; i < n; i++) begin
                    acc = 0;
                    for (int j = 0; j < n; j++)
                        acc += round_product(coef_mem[i * NS + j], state_mem[j]);
                    if (b_en)
                        for (int j = 0; j < m; j++)
                            acc += round_product(coef_mem[OFS_B + i * NI + j], u[j]);
                    ovf |= (acc > WORD_MAX) || (acc < WORD_MIN);
                    nx[i] = clip_to_word(acc);
                end
                // inactive elements keep their value and report zero
                for (int i = 0; i < n; i++)
                    state_mem[i] = nx[i];
                r.kind = 1'b1;
                r.overflow = ovf;
                r.y_first = y[0];
                r.y_second = y[1];
                r.next_x0 = nx[0];
                r.next_x1 = nx[1];
                r.next_x2 = nx[2];
                r.next_x3 = nx[3];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_output();
        filter_result_t got;
        filter_result_t want;
        got.kind = m_axis_tuser[0];
        got.overflow = m_axis_tuser[1];
        got.y_first = m_axis_tdata[31:0];
        got.y_second = m_axis_tdata[63:32];
        got.next_x0 = m_axis_tdata[95:64];
        got.next_x1 = m_axis_tdata[127:96];
        got.next_x2 = m_axis_tdata[159:128];
        got.next_x3 = m_axis_tdata[191:160];
        if (expected_outputs.size() == 0) begin
            report("unexpected result", 32'(got.kind), 32'h0);
            return;
        end
        want = expected_outputs.pop_front();
        if (want.kind)
            steps_seen++;
        if (want.overflow)
            saturated_seen++;
        if (got.kind !== want.kind)
            report("kind", 32'(got.kind), 32'(want.kind));
        if (got.overflow !== want.overflow)
            report("overflow", 32'(got.overflow), 32'(want.overflow));
        if (got.y_first !== want.y_first)
            report("y_first", got.y_first, want.y_first);
        if (got.y_second !== want.y_second)
            report("y_second", got.y_second, want.y_second);
        if (got.next_x0 !== want.next_x0)
            report("next_x0", got.next_x0, want.next_x0);
        if (got.next_x1 !== want.next_x1)
            report("next_x1", got.next_x1, want.next_x1);
        if (got.next_x2 !== want.next_x2)
            report("next_x2", got.next_x2, want.next_x2);
        if (got.next_x3 !== want.next_x3)
            report("next_x3", got.next_x3, want.next_x3);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < COEF_DEPTH; k++)
                coef_mem[k] = '0;
            for (int k = 0; k < NS; k++)
                state_mem[k] = '0;
            n_cfg = 3'd1;
            m_cfg = 2'd1;
            p_cfg = 2'd1;
            b_en = 1'b1;
            c_en = 1'b1;
            d_en = 1'b1;
            expected_outputs.delete();
            mismatches = 0;
            steps_seen = 0;
            saturated_seen = 0;
            fail_count <= 0;
            pending <= 0;
            step_results <= 0;
            saturated_results <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_STATES_USED:  n_cfg = pwdata[2:0];
                    REG_INPUTS_USED:  m_cfg = pwdata[1:0];
                    REG_OUTPUTS_USED: p_cfg = pwdata[1:0];
                    REG_USE_B:        b_en = pwdata[0];
                    REG_USE_C:        c_en = pwdata[0];
                    REG_USE_D:        d_en = pwdata[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_outputs.push_back(advance_filter(mode_t'(s_axis_tuser[1:0]),
                    msel_t'(s_axis_tuser[3:2]), s_axis_tdata[1:0], s_axis_tdata[3:2],
                    s_axis_tdata[35:4], s_axis_tdata[67:36], s_axis_tdata[99:68]));
            if (m_axis_tvalid && m_axis_tready)
                check_output();
            fail_count <= mismatches;
            pending <= expected_outputs.size();
            step_results <= steps_seen;
            saturated_results <= saturated_seen;
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the state-space filter: loads coefficient sets and initial
// states over the input stream, runs sample steps under many register
// settings with random idling on both streams, and lets the checker compare
// every result against its own prediction.
// ----------------------------------------------------------------------------
module testbench;
    import ssf_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 12;
    localparam int STEPS_PER_PHASE = 120;
    // accepted transactions before the receiver's long hold-off starts
    localparam int HOLD_AFTER = 700;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int ONE = 32'sh0001_0000;   // 1.0 in Q16.16

    logic clk = 1'b0;
    logic rst_n;

    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // row[1:0], col[3:2], value[35:4], u_first[67:36], u_second[99:68], zero
    logic [IN_TDATA_W-1:0]     s_axis_tdata;
    // mode[1:0], matrix_sel[3:2]
    logic [IN_TUSER_W-1:0]     s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // y_first[31:0], y_second[63:32], next_x0[95:64], next_x1[127:96],
    // next_x2[159:128], next_x3[191:160]
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    // kind[0], overflow[1]
    logic [OUT_TUSER_W-1:0]    m_axis_tuser;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // results handed up by the checker
    int fail_count;
    int pending;
    int step_results;
    int saturated_results;

    int  cycles = 0;
    int  items_in = 0;
    int  settings = 0;
    bit  burst_phase = 1'b0;    // sender adds no random idle gaps during this phase
    bit  hold_active = 1'b0;    // receiver is in its long hold-off
    bit  hold_done = 1'b0;

    always #1 clk = ~clk;

    state_space_filter i_dut (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    state_space_checker i_checker (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .psel,
        .penable,
        .pwrite,
        .pready,
        .paddr,
        .pwdata,
        .fail_count,
        .pending,
        .step_results,
        .saturated_results
    );

    // watchdog, sized for the slowest legal run several times over
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // value mix: mostly small fixed-point numbers, some full range, some extremes
    function automatic data_t pick_value(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            case ($urandom_range(0, 5))
                0:       return 32'sh7fff_ffff;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                3:       return -32'sd1;
                4:       return ONE;
                default: return -ONE;
            endcase
        end
        if (r < 20)
            return data_t'($urandom);
        return data_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // sender idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (hold_active || burst_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input transaction; called at a rising edge, returns at one
    task automatic send_item(mode_t mode, msel_t sel, logic [1:0] row, logic [1:0] col,
                             data_t value, data_t u_first, data_t u_second);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sel, mode};
        s_axis_tdata  <= {4'b0000, u_second, u_first, value, col, row};
        do @(posedge clk); while (!s_axis_tready);
        items_in++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_coef(msel_t sel, int row, int col, data_t value);
        send_item(MODE_COEF, sel, row[1:0], col[1:0], value, data_t'($urandom),
                  data_t'($urandom));
    endtask

    task automatic write_state(int row, data_t value);
        send_item(MODE_STATE, msel_t'($urandom_range(0, 3)), row[1:0],
                  2'($urandom_range(0, 3)), value, data_t'($urandom), data_t'($urandom));
    endtask

    task automatic sample(data_t u_first, data_t u_second);
        send_item(MODE_STEP, msel_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), data_t'($urandom), u_first, u_second);
    endtask

    // stop offering and wait until every expected result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // setup and access phase; psel stays high so writes run back to back
    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // block must be idle here: called only after wait_drained or reset
    task automatic program_filter(int n, int m, int p, int b, int c, int d);
        write_reg(REG_STATES_USED, n);
        write_reg(REG_INPUTS_USED, m);
        write_reg(REG_OUTPUTS_USED, p);
        write_reg(REG_USE_B, b);
        write_reg(REG_USE_C, c);
        write_reg(REG_USE_D, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    // fill a whole matrix at its maximum size with random content
    task automatic load_matrix(msel_t sel, int rows, int cols, int span);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                write_coef(sel, r, c, pick_value(span));
    endtask

    // one register setting: fresh coefficients and state, then sample steps with noise
    task automatic run_phase(int phase);
        int r;
        // a stable-ish A keeps most trajectories away from the rails
        load_matrix(SEL_A, MAX_STATES_DEF, MAX_STATES_DEF, ONE / 4);
        load_matrix(SEL_B, MAX_STATES_DEF, MAX_INPUTS_DEF, ONE);
        load_matrix(SEL_C, MAX_OUTPUTS_DEF, MAX_STATES_DEF, ONE);
        load_matrix(SEL_D, MAX_OUTPUTS_DEF, MAX_INPUTS_DEF, ONE);
        for (int k = 0; k < MAX_STATES_DEF; k++)
            write_state(k, pick_value(4 * ONE));
        for (int k = 0; k < STEPS_PER_PHASE; k++) begin
            // sender pause until the pipeline has fully drained
            if (k == STEPS_PER_PHASE / 2 && phase % 3 == 2)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 88)
                sample(pick_value(2 * ONE), pick_value(2 * ONE));
            else
                // noise: any mode including the unused one, any index, full-range data
                send_item(mode_t'($urandom_range(0, 3)), msel_t'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          data_t'($urandom), data_t'($urandom), data_t'($urandom));
        end
    endtask

    // output side: random ready pattern plus one long hold-off to fill the block
    initial begin : output_sink
        int span;
        int r;
        span = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!hold_done && items_in >= HOLD_AFTER) begin
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_done = 1'b1;
                span = 0;
            end
            else if (span > 0)
                span--;
            else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_axis_tready <= 1'b1;
                    span = $urandom_range(0, 7);
                end
                else if (r < 88) begin
                    m_axis_tready <= 1'b0;
                    span = $urandom_range(0, 2);
                end
                else if (r < 94) begin
                    m_axis_tready <= 1'b0;
                    span = $urandom_range(10, 40);
                end
                else begin
                    // stretch with no stall at all
                    m_axis_tready <= 1'b1;
                    span = $urandom_range(50, 150);
                end
            end
        end
    end

    initial begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cleared store at reset settings, then unused mode
        sample(32'sh7fff_ffff, 32'sh8000_0000);
        send_item(MODE_NONE, SEL_D, 2'd3, 2'd3, 32'sh7fff_ffff, -32'sd1, -32'sd1);
        wait_drained();
        program_filter(4, 2, 2, 1, 1, 1);

        // directed: corner coefficients, out-of-range indexes ignored but acknowledged
        write_coef(SEL_A, 3, 3, 32'sh7fff_ffff);
        write_coef(SEL_A, 0, 0, ONE);
        write_coef(SEL_B, 3, 1, 32'sh8000_0000);
        write_coef(SEL_B, 0, 2, 32'sh1234_5678);
        write_coef(SEL_B, 1, 0, ONE);
        write_coef(SEL_C, 1, 3, -ONE);
        write_coef(SEL_C, 2, 0, 32'sh7fff_ffff);
        write_coef(SEL_C, 0, 0, ONE);
        write_coef(SEL_D, 1, 1, 32'sh7fff_ffff);
        write_coef(SEL_D, 3, 3, -32'sd1);
        write_coef(SEL_D, 0, 0, 32'sh8000_0000);
        write_state(3, 32'sh7fff_ffff);
        write_state(0, 32'sh8000_0000);
        write_state(1, ONE);
        // extreme inputs drive both outputs and state into saturation
        sample(32'sh7fff_ffff, 32'sh8000_0000);
        sample(32'sh0000_0000, 32'sh0000_0000);
        sample(-32'sd1, 32'sd1);
        write_state(2, -32'sd1);
        sample(ONE, ONE);
        wait_drained();

        // fixed corners of the register space first, random settings after
        for (int ph = 0; ph < PHASES; ph++) begin
            burst_phase = (ph % 4 == 1);
            case (ph)
                0:       program_filter(4, 2, 2, 1, 1, 1);
                1:       program_filter(1, 1, 1, 0, 0, 0);
                2:       program_filter(0, 0, 0, 1, 1, 0);   // zero counts read as one
                3:       program_filter(7, 3, 3, 1, 0, 1);   // counts above maximum
                4:       program_filter(2, 2, 1, 0, 1, 1);
                5:       program_filter(3, 1, 2, 1, 1, 0);
                default: program_filter($urandom_range(0, 7), $urandom_range(0, 3),
                                        $urandom_range(0, 3), $urandom_range(0, 1),
                                        $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            run_phase(ph);
            wait_drained();
        end
        burst_phase = 1'b0;

        // all results are in; give the block room to show any stray output
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d input transactions over %0d register settings",
                 items_in, settings);
        $display("%0d sample steps checked, %0d of them saturated, %0d mismatches",
                 step_results, saturated_results, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- state_space_filter.f -----
rtl/ssf_pkg.sv
rtl/ssf_dot_row.sv
rtl/state_space_filter.sv
bench/state_space_checker.sv
bench/testbench.sv
